// ===== rtl/core/cgs_pkg.sv =====
`timescale 1ns / 1ps
// Package for the 3x3 grayscale convolution block: payload structs, register
// indexes, reset values and sizing constants. No dependencies.
package cgs_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int Q_DEPTH_DEF   = 4;

    localparam int PIX_W   = 8;
    localparam int OCOL_W  = 10;
    localparam int IWID_W  = 11;
    localparam int KROW_W  = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 2'd3;

    localparam logic [IWID_W-1:0] IMAGE_WIDTH_RST   = 11'd1024;
    localparam logic [KROW_W-1:0] KERNEL_TOP_RST    = 24'h000000;
    localparam logic [KROW_W-1:0] KERNEL_MID_RST    = 24'h000100;
    localparam logic [KROW_W-1:0] KERNEL_BOTTOM_RST = 24'h000000;

    // row counter saturates here: from this row on, interior columns give results
    localparam logic [1:0] ROW_SAT = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             frame_start;
    } in_t;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel_out;
        logic [OCOL_W-1:0] out_column;
        logic              row_last;
    } out_t;

    // one queued window: index row*3 + col, row 0 oldest, col 0 leftmost
    typedef struct packed {
        logic [8:0][PIX_W-1:0] win;
        logic [OCOL_W-1:0]     out_column;
        logic                  row_last;
    } q_entry_t;

    typedef struct packed {
        logic [KROW_W-1:0] top;
        logic [KROW_W-1:0] mid;
        logic [KROW_W-1:0] bottom;
    } kernel_t;

endpackage

// ===== rtl/core/cgs_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/cgs_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts pixels, tracks row/column, keeps both line buffers and the
// 3x3 window, and pushes result-bearing windows to the queue. Uses cgs_pkg, cgs_ram.
module cgs_front #(
    parameter int Q_DEPTH   = cgs_pkg::Q_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cgs_pkg::in_t                    s_data,
    input  logic [cgs_pkg::IWID_W-1:0]      image_width,
    input  logic [$clog2(Q_DEPTH+1)-1:0]    q_count,
    output logic                            push,
    output cgs_pkg::q_entry_t               push_data
);

    localparam int MAX_WIDTH = cgs_pkg::MAX_WIDTH_DEF;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW   = (CW + 1 > cgs_pkg::IWID_W) ? CW + 1 : cgs_pkg::IWID_W;
    localparam int CNTW = $clog2(Q_DEPTH + 1);
    localparam int PW   = cgs_pkg::PIX_W;

    logic [CW-1:0]  col_reg, col_next;
    logic [1:0]     row_reg, row_next;
    logic           s1_valid_reg;
    logic [PW-1:0]  s1_pix_reg;
    logic [CW-1:0]  s1_addr_reg;
    logic           s1_prod_reg;
    logic [cgs_pkg::OCOL_W-1:0] s1_col_reg;
    logic           s1_last_reg;
    logic           s1_fwd_reg;
    logic [2*PW-1:0] fwd_data_reg;
    logic [8:0][PW-1:0] win_reg, win_next;

    logic           accept;
    logic [CW-1:0]  c_cur, c_m1;
    logic [1:0]     row_cur;
    logic [EW-1:0]  w_ext, w_eff;
    logic           last;
    logic           prod;
    logic [CNTW:0]  occ;
    logic [2*PW-1:0] lines, ram_rdata, ram_wdata;

    // hold back input while the queue plus the word in flight could overflow it
    assign occ     = {1'b0, q_count} + (CNTW+1)'(s1_valid_reg);
    assign s_ready = occ < (CNTW+1)'(Q_DEPTH);
    assign accept  = s_valid && s_ready;

    assign c_cur   = s_data.frame_start ? '0 : col_reg;
    assign row_cur = s_data.frame_start ? 2'd0 : row_reg;
    assign c_m1    = c_cur - CW'(1);

    always_comb begin
        w_ext = EW'(image_width);
        if (w_ext < EW'(3)) begin
            w_eff = EW'(3);
        end else if (w_ext > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
    end

    assign last = EW'(c_cur) >= (w_eff - EW'(1));
    assign prod = (row_cur == cgs_pkg::ROW_SAT) && (c_cur >= CW'(2));

    always_comb begin
        col_next = last ? '0 : c_cur + CW'(1);
        row_next = (last && row_cur != cgs_pkg::ROW_SAT) ? row_cur + 2'd1 : row_cur;
    end

    // line buffers: {older, newer} share one address
    assign lines     = s1_fwd_reg ? fwd_data_reg : ram_rdata;
    assign ram_wdata = {lines[PW-1:0], s1_pix_reg};

    cgs_ram #(
        .WIDTH (2*PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (ram_wdata),
        .raddr (c_cur),
        .rdata (ram_rdata)
    );

    always_comb begin
        win_next = win_reg;
        for (int r = 0; r < 3; r++) begin
            win_next[r*3]   = win_reg[r*3+1];
            win_next[r*3+1] = win_reg[r*3+2];
        end
        win_next[2] = lines[2*PW-1:PW];
        win_next[5] = lines[PW-1:0];
        win_next[8] = s1_pix_reg;
    end

    assign push                 = s1_valid_reg && s1_prod_reg;
    assign push_data.win        = win_next;
    assign push_data.out_column = s1_col_reg;
    assign push_data.row_last   = s1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            win_reg      <= '0;
        end else begin
            s1_valid_reg <= accept;
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s1_valid_reg) begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg   <= s_data.pixel_in;
            s1_addr_reg  <= c_cur;
            s1_prod_reg  <= prod;
            s1_col_reg   <= cgs_pkg::OCOL_W'(c_m1);
            s1_last_reg  <= last;
            // read collides with the write in flight: take the written word
            s1_fwd_reg   <= s1_valid_reg && (s1_addr_reg == c_cur);
            fwd_data_reg <= ram_wdata;
        end
    end

endmodule

// ===== rtl/core/cgs_fifo.sv =====
`timescale 1ns / 1ps
// Short register queue between front and back end.
// Uses cgs_pkg.
module cgs_fifo #(
    parameter int DEPTH = cgs_pkg::Q_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  cgs_pkg::q_entry_t            push_data,
    input  logic                         pop,
    output cgs_pkg::q_entry_t            pop_data,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTW = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    cgs_pkg::q_entry_t mem_reg [DEPTH];
    logic [PTW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNW-1:0]    count_reg;

    function automatic logic [PTW-1:0] ptr_inc(input logic [PTW-1:0] p);
        return (p == PTW'(DEPTH - 1)) ? '0 : p + PTW'(1);
    endfunction

    assign pop_data = mem_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/cgs_back.sv =====
`timescale 1ns / 1ps
// Back end: nine multiplies, row sums, total and clamp, output register.
// Uses cgs_pkg.
module cgs_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  cgs_pkg::kernel_t   kernel,
    input  logic               q_empty,
    input  cgs_pkg::q_entry_t  q_data,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output cgs_pkg::out_t      m_data
);

    localparam int PW   = cgs_pkg::PIX_W;
    localparam int PRW  = 2 * PW + 1;
    localparam int RSW  = PRW + 2;
    localparam int TSW  = RSW + 2;

    logic                 advance;
    logic                 a_valid_reg, b_valid_reg, m_valid_reg;
    logic signed [PRW-1:0] prod_reg [9];
    logic signed [RSW-1:0] rsum_reg [3];
    logic [cgs_pkg::OCOL_W-1:0] a_col_reg, b_col_reg;
    logic                 a_last_reg, b_last_reg;
    cgs_pkg::out_t        m_data_reg;

    logic [2:0][cgs_pkg::KROW_W-1:0] krows;
    logic signed [PRW-1:0] prod_next [9];
    logic signed [RSW-1:0] rsum_next [3];
    logic signed [TSW-1:0] total;
    logic [PW-1:0]         clamped;

    // the whole pipeline moves when the output register can take a word
    assign advance = !m_valid_reg || m_ready;
    assign pop     = advance && !q_empty;

    assign krows = {kernel.bottom, kernel.mid, kernel.top};

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                prod_next[r*3+k] = PRW'($signed({1'b0, q_data.win[r*3+k]})
                                        * $signed(krows[r][k*PW +: PW]));
            end
        end
        for (int r = 0; r < 3; r++) begin
            rsum_next[r] = RSW'(prod_reg[r*3]) + RSW'(prod_reg[r*3+1])
                         + RSW'(prod_reg[r*3+2]);
        end
        total = TSW'(rsum_reg[0]) + TSW'(rsum_reg[1]) + TSW'(rsum_reg[2]);
        if (total < 0) begin
            clamped = '0;
        end else if (total > TSW'(255)) begin
            clamped = '1;
        end else begin
            clamped = total[PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= !q_empty;
            b_valid_reg <= a_valid_reg;
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg   <= prod_next;
            a_col_reg  <= q_data.out_column;
            a_last_reg <= q_data.row_last;
            rsum_reg   <= rsum_next;
            b_col_reg  <= a_col_reg;
            b_last_reg <= a_last_reg;
            m_data_reg.pixel_out  <= clamped;
            m_data_reg.out_column <= b_col_reg;
            m_data_reg.row_last   <= b_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/conv3x3_gray_saturate.sv =====
`timescale 1ns / 1ps
// 3x3 grayscale correlation with clamp to 0..255; top level.
// A result passes the front register, the queue, then the back end's product, row-sum and output registers.
// Throughput: one pixel per cycle while the queue has room, set by the single-port-pair line RAM
// (one read and one write per pixel).
// Reset (aresetn low, synchronous): counters, window, queue and pipeline valids
// clear, registers take their reset values; line RAM contents are left as is.
module conv3x3_gray_saturate #(
    parameter int Q_DEPTH   = cgs_pkg::Q_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes, taken whenever cfg_we is high
    input  logic                              cfg_we,
    input  logic [cgs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cgs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // pixel input words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  cgs_pkg::in_t                      s_data,
    // result words
    output logic                              m_valid,
    input  logic                              m_ready,
    output cgs_pkg::out_t                     m_data
);

    logic [cgs_pkg::IWID_W-1:0] image_width_reg;
    cgs_pkg::kernel_t           kernel_reg;

    logic                       push;
    cgs_pkg::q_entry_t          push_data;
    logic                       pop;
    cgs_pkg::q_entry_t          pop_data;
    logic                       q_empty;
    logic [$clog2(Q_DEPTH+1)-1:0] q_count;

    // Register file: no read-back, each write lands in the indexed register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg   <= cgs_pkg::IMAGE_WIDTH_RST;
            kernel_reg.top    <= cgs_pkg::KERNEL_TOP_RST;
            kernel_reg.mid    <= cgs_pkg::KERNEL_MID_RST;
            kernel_reg.bottom <= cgs_pkg::KERNEL_BOTTOM_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                cgs_pkg::REG_IMAGE_WIDTH: begin
                    image_width_reg <= cfg_wdata[cgs_pkg::IWID_W-1:0];
                end
                cgs_pkg::REG_KERNEL_TOP: begin
                    kernel_reg.top <= cfg_wdata;
                end
                cgs_pkg::REG_KERNEL_MID: begin
                    kernel_reg.mid <= cfg_wdata;
                end
                cgs_pkg::REG_KERNEL_BOTTOM: begin
                    kernel_reg.bottom <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Front: count columns and rows, shift the window through the line RAM,
    // and push only the windows that produce a result. It stalls input on
    // queue occupancy alone, so it never sees m_ready directly.
    cgs_front #(
        .Q_DEPTH   (Q_DEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .image_width (image_width_reg),
        .q_count     (q_count),
        .push        (push),
        .push_data   (push_data)
    );

    // Queue: decouples the window producer from the multiply-accumulate side.
    cgs_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty),
        .count     (q_count)
    );

    // Back: products, row sums, total with clamp into the output register.
    cgs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .kernel  (kernel_reg),
        .q_empty (q_empty),
        .q_data  (pop_data),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== rtl/core/cgs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the convolution top level, attached by bind.
// Uses cgs_pkg.
module cgs_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input cgs_pkg::out_t m_data
);

    logic [31:0] pending_reg;
    logic        prev_last_reg;
    logic        in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= '0;
            prev_last_reg <= 1'b1;
        end else begin
            if (in_acc && !out_acc) begin
                pending_reg <= pending_reg + 32'd1;
            end else if (out_acc && !in_acc) begin
                pending_reg <= pending_reg - 32'd1;
            end
            if (out_acc) begin
                prev_last_reg <= m_data.row_last;
            end
        end
    end

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // every result comes from an earlier accepted pixel
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> pending_reg != 32'd0)
        else $error("result without an outstanding pixel");

    // the first result after a row end sits in column one
    a_row_start: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && prev_last_reg |-> m_data.out_column == 10'd1)
        else $error("new output row does not start at column one");

    // border column zero never yields a result
    a_no_border: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.out_column != 10'd0)
        else $error("result in border column");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word present after reset");

endmodule

bind conv3x3_gray_saturate cgs_checker u_cgs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== verif/conv3x3_checker.sv =====
`timescale 1ns / 1ps
// Checker for conv3x3_gray_saturate: watches the config port and both word channels,
// predicts each result word and compares it with what the block delivers. Uses cgs_pkg.
module conv3x3_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [cgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cgs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  cgs_pkg::in_t                   s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  cgs_pkg::out_t                  m_data,
    output int                             fail_count,
    output int                             pending
);
    import cgs_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH_DEF;

    logic [IWID_W-1:0] width_reg;
    logic [KROW_W-1:0] kernel_rows [3];
    logic [PIX_W-1:0]  older_line [LINE_DEPTH];
    logic [PIX_W-1:0]  newer_line [LINE_DEPTH];
    logic [PIX_W-1:0]  window [9];
    int unsigned       col_cnt;
    int unsigned       row_cnt;
    out_t              expected_results [$];

    function automatic int coefficient(input logic [KROW_W-1:0] krow, input int k);
        logic signed [7:0] b;
        b = krow[8*k +: 8];
        return int'(b);
    endfunction

    task automatic note_mismatch(input string what, input out_t want, input out_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s: expected pix=%0d col=%0d last=%0b, got pix=%0d col=%0d last=%0b",
                     $realtime, what, want.pixel_out, want.out_column, want.row_last,
                     got.pixel_out, got.out_column, got.row_last);
    endtask

    // One accepted pixel word: shift window, rotate line stores, maybe emit a result.
    task automatic correlate_pixel(input in_t word);
        int unsigned eff_w;
        int unsigned c;
        int unsigned idx;
        logic        at_end;
        int          acc;
        out_t        res;
        eff_w = width_reg;
        if (eff_w < 3) eff_w = 3;
        if (eff_w > LINE_DEPTH) eff_w = LINE_DEPTH;
        if (word.frame_start) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        c   = col_cnt;
        idx = c % LINE_DEPTH;
        for (int r = 0; r < 3; r++) begin
            window[r*3]   = window[r*3+1];
            window[r*3+1] = window[r*3+2];
        end
        window[2] = older_line[idx];
        window[5] = newer_line[idx];
        window[8] = word.pixel_in;
        older_line[idx] = newer_line[idx];
        newer_line[idx] = word.pixel_in;
        at_end = (c >= eff_w - 1);
        if (row_cnt >= 2 && c >= 2) begin
            acc = 0;
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 3; k++)
                    acc += int'(window[r*3+k]) * coefficient(kernel_rows[r], k);
            if (acc < 0) acc = 0;
            if (acc > 255) acc = 255;
            res.pixel_out  = acc[7:0];
            res.out_column = OCOL_W'(c - 1);
            res.row_last   = at_end;
            expected_results.push_back(res);
        end
        if (at_end) begin
            col_cnt = 0;
            if (row_cnt < 2) row_cnt++;
        end else begin
            col_cnt = c + 1;
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            width_reg      = IMAGE_WIDTH_RST;
            kernel_rows[0] = KERNEL_TOP_RST;
            kernel_rows[1] = KERNEL_MID_RST;
            kernel_rows[2] = KERNEL_BOTTOM_RST;
            for (int i = 0; i < 9; i++) window[i] = '0;
            col_cnt = 0;
            row_cnt = 0;
            expected_results.delete();
        end else begin
            // results leaving now come from earlier pixels: check before predicting
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected result", '0, m_data);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.pixel_out !== want.pixel_out ||
                        m_data.out_column !== want.out_column ||
                        m_data.row_last !== want.row_last)
                        note_mismatch("result mismatch", want, m_data);
                end
            end
            if (s_valid && s_ready) correlate_pixel(s_data);
            if (cfg_we) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:   width_reg      = cfg_wdata[IWID_W-1:0];
                    REG_KERNEL_TOP:    kernel_rows[0] = cfg_wdata[KROW_W-1:0];
                    REG_KERNEL_MID:    kernel_rows[1] = cfg_wdata[KROW_W-1:0];
                    REG_KERNEL_BOTTOM: kernel_rows[2] = cfg_wdata[KROW_W-1:0];
                    default: ;
                endcase
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Top of the conv3x3_gray_saturate bench: clock, reset, pixel stimulus, result
// back-pressure, watchdog and verdict. Needs cgs_pkg, the block and conv3x3_checker.
module testbench;
    import cgs_pkg::*;

    localparam int RANDOM_ITEMS = 250;
    localparam int WARM_WIDTH   = 80;    // widest row the random phases use
    localparam int IDLE_LIMIT   = 2000;  // cycles with no word moving on either channel
    localparam int SETTLE       = 10;    // drain tail, for words still in flight

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_t                  m_data;

    int fail_count;
    int pending;

    int burst_left   = 0;
    bit steady       = 0;
    int random_items = 0;
    int idle_cycles  = 0;

    conv3x3_gray_saturate i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    conv3x3_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Receiver: switch between back-pressure styles every so often, so stalls
    // land on every part of the pipeline, with fully open stretches in between.
    int rx_mode    = 0;
    int rx_left    = 0;
    int stall_left = 0;
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(40, 200);
        end
        rx_left--;
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: begin
                // long stalls: hold ready low for a run of cycles
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 15);
                end
            end
        endcase
    end

    // Watchdog: a hung block shows as a long run of cycles where no word moves.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Send one pixel word. Gaps open only between bursts; a zero gap keeps valid
    // high so it is never dropped and raised in the same step.
    task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= '{pixel_in: pix, frame_start: fs};
        // hold the word until the block takes it
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        @(negedge aclk);
    endtask

    // Drop valid and wait for every predicted result to come out, then let the
    // pipeline settle (pixels that give no result may still be in flight).
    task automatic drain(input int tail);
        s_valid <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (tail) @(negedge aclk);
    endtask

    // Write all four registers on back-to-back cycles; only called while idle.
    // Junk goes into the unused upper bits of the width word.
    task automatic program_regs(input logic [IWID_W-1:0] width, input logic [KROW_W-1:0] ktop,
                                input logic [KROW_W-1:0] kmid, input logic [KROW_W-1:0] kbot);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_wdata <= {13'($urandom), width};
        @(negedge aclk);
        cfg_index <= REG_KERNEL_TOP;
        cfg_wdata <= ktop;
        @(negedge aclk);
        cfg_index <= REG_KERNEL_MID;
        cfg_wdata <= kmid;
        @(negedge aclk);
        cfg_index <= REG_KERNEL_BOTTOM;
        cfg_wdata <= kbot;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // Kernel row for a given style: 0 random, 1 small taps (mostly unclamped
    // sums), 2 all +127, 3 all -128, 4 identity.
    function automatic logic [KROW_W-1:0] pick_kernel_row(input int style, input int row);
        logic [KROW_W-1:0] k;
        case (style)
            0: k = KROW_W'($urandom);
            1: for (int i = 0; i < 3; i++) k[8*i +: 8] = 8'($urandom_range(0, 4) - 2);
            2: k = 24'h7F7F7F;
            3: k = 24'h808080;
            default: k = (row == 1) ? KERNEL_MID_RST : '0;
        endcase
        return k;
    endfunction

    initial begin
        int               width;
        int               rows;
        int               style;
        int               count;
        bit               start_frame;
        logic [KROW_W-1:0] kt;
        logic [KROW_W-1:0] km;
        logic [KROW_W-1:0] kb;
        int               phase;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Warm-up with the identity kernel at the widest random row: three rows
        // fill every line store entry the later phases can read.
        program_regs(11'(WARM_WIDTH), KERNEL_TOP_RST, KERNEL_MID_RST, KERNEL_BOTTOM_RST);
        for (int i = 0; i < 3 * WARM_WIDTH; i++) push_pixel(pick_pixel(), i == 0);
        drain(SETTLE);

        // Narrowest width, all taps +127: sums saturate high.
        program_regs(11'd3, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
        push_pixel(8'd0, 1'b1);   push_pixel(8'd255, 1'b0); push_pixel(8'd0, 1'b0);
        push_pixel(8'd255, 1'b0); push_pixel(8'd255, 1'b0); push_pixel(8'd255, 1'b0);
        push_pixel(8'd255, 1'b0); push_pixel(8'd0, 1'b0);   push_pixel(8'd255, 1'b0);
        push_pixel(8'd0, 1'b0);   push_pixel(8'd0, 1'b0);   push_pixel(8'd0, 1'b0);
        drain(SETTLE);

        // Width zero acts as three; all taps -128 clamp low. A frame start lands
        // mid-row, so results wait for two fresh rows.
        program_regs(11'd0, 24'h808080, 24'h808080, 24'h808080);
        for (int i = 0; i < 5; i++) push_pixel(8'd255, i == 0);
        for (int i = 0; i < 9; i++) push_pixel(8'd255, i == 0);
        drain(SETTLE);

        // Width beyond the line store acts as the maximum: a short first row
        // never reaches its end, so nothing comes out.
        program_regs(11'd2047, pick_kernel_row(1, 0), pick_kernel_row(1, 1),
                     pick_kernel_row(1, 2));
        for (int i = 0; i < 40; i++) push_pixel(pick_pixel(), i == 0);
        drain(SETTLE);

        // Random phases: new settings each time, mostly well-formed frames
        // with random content, some stray frame starts and mid-row restarts.
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       width = $urandom_range(0, 2);
                1:       width = $urandom_range(25, WARM_WIDTH);
                default: width = $urandom_range(3, 24);
            endcase
            style = $urandom_range(0, 9);
            if (style >= 5) style = 1;
            kt = pick_kernel_row(style, 0);
            km = pick_kernel_row(style, 1);
            kb = pick_kernel_row(style, 2);
            program_regs(11'(width), kt, km, kb);

            steady      = ($urandom_range(0, 3) == 0);
            start_frame = ($urandom_range(0, 6) != 0);
            rows        = $urandom_range(3, 6);
            count       = rows * ((width < 3) ? 3 : width);
            for (int i = 0; i < count; i++) begin
                // every other phase, pause midway until the output side is empty
                if (phase % 2 == 1 && i == count / 2) drain(0);
                push_pixel(pick_pixel(), (i == 0 && start_frame) ||
                                         ($urandom_range(0, 39) == 0));
                random_items++;
            end
            drain(SETTLE);
            phase++;
        end

        // everything is drained and settled by the last drain
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
